[src/trint_pkg.sv]
package trint_pkg;

    localparam int ACC_W = 32;
    localparam int THR_W = 15;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic REG_NOISE_THRESHOLD = 1'b0;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic found;
        logic last;
        logic first;
    } trint_flags_t;

endpackage

[src/trint_apb.sv]
module trint_apb
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [trint_pkg::ADDR_W-1:0]      paddr,
    input  logic [trint_pkg::DATA_W-1:0]      pwdata,
    output logic [trint_pkg::DATA_W-1:0]      prdata,
    output logic                              pready,
    output logic [trint_pkg::THR_W-1:0]       noise_threshold
);

    logic [trint_pkg::THR_W-1:0] thr_reg;
    logic [trint_pkg::THR_W-1:0] thr_next;
    logic                        sel_thr;

    assign pready = 1'b1;
    assign sel_thr = (paddr[trint_pkg::ADDR_W-1:2] == trint_pkg::REG_NOISE_THRESHOLD);

    always_comb
    begin
        thr_next = thr_reg;
        if (psel && penable && pwrite && pready && sel_thr)
        begin
            thr_next = pwdata[trint_pkg::THR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_thr)
        begin
            prdata = trint_pkg::DATA_W'(thr_reg);
        end
    end

    assign noise_threshold = thr_reg;

endmodule

[src/trint_integ.sv]
module trint_integ
#(
    parameter int SAMPLE_BITS = 16,
    parameter int IDX_W = 16,
    parameter int MAX_SAMPLES = 65536
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  step,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    input  trint_pkg::trint_flags_t               flags,
    input  logic [trint_pkg::THR_W-1:0]           threshold,
    output logic signed [trint_pkg::ACC_W-1:0]    running_sum,
    output logic [IDX_W-1:0]                      sample_index,
    output logic signed [trint_pkg::ACC_W-1:0]    peak_high_value,
    output logic [IDX_W-1:0]                      peak_high_index,
    output logic signed [trint_pkg::ACC_W-1:0]    peak_low_value,
    output logic [IDX_W-1:0]                      peak_low_index,
    output logic                                  emit
);

    localparam int AW = trint_pkg::ACC_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SAMPLES - 1);

    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] acc_next;
    logic signed [AW-1:0] hv_reg;
    logic signed [AW-1:0] hv_next;
    logic [IDX_W-1:0]     hi_reg;
    logic [IDX_W-1:0]     hi_next;
    logic signed [AW-1:0] lv_reg;
    logic signed [AW-1:0] lv_next;
    logic [IDX_W-1:0]     li_reg;
    logic [IDX_W-1:0]     li_next;
    logic [IDX_W-1:0]     pos_reg;
    logic [IDX_W-1:0]     pos_next;
    logic                 sup_reg;
    logic                 sup_next;

    logic                 start;
    logic [IDX_W-1:0]     idx;
    logic signed [AW-1:0] s_ext;
    logic signed [SAMPLE_BITS:0] s_wide;
    logic [SAMPLE_BITS:0] mag;
    logic                 above;
    logic signed [AW:0]   sum;
    logic signed [AW-1:0] sum_sat;

    always_comb
    begin
        s_ext = {{(AW-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
        s_wide = {sample[SAMPLE_BITS-1], sample};
        mag = sample[SAMPLE_BITS-1] ? (SAMPLE_BITS+1)'(-s_wide) : s_wide;
        above = (AW'(mag) > AW'(threshold));
        sum = {acc_reg[AW-1], acc_reg} + {s_ext[AW-1], s_ext};
        if (sum[AW] != sum[AW-1])
        begin
            sum_sat = sum[AW] ? trint_pkg::ACC_MIN : trint_pkg::ACC_MAX;
        end
        else
        begin
            sum_sat = sum[AW-1:0];
        end

        start = flags.first || (pos_reg == '0);
        idx = start ? '0 : pos_reg;

        acc_next = acc_reg;
        hv_next = hv_reg;
        hi_next = hi_reg;
        lv_next = lv_reg;
        li_next = li_reg;
        sup_next = sup_reg;

        if (start)
        begin
            sup_next = !flags.found;
            acc_next = s_ext;
            hv_next = s_ext;
            hi_next = '0;
            lv_next = s_ext;
            li_next = '0;
        end
        else
        begin
            if (above)
            begin
                acc_next = sum_sat;
            end
            if (acc_next > hv_reg)
            begin
                hv_next = acc_next;
                hi_next = idx;
            end
            if (acc_next < lv_reg)
            begin
                lv_next = acc_next;
                li_next = idx;
            end
        end

        if (flags.last)
        begin
            pos_next = '0;
        end
        else if (idx != IDX_LAST)
        begin
            pos_next = idx + 1'b1;
        end
        else
        begin
            pos_next = idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            hv_reg <= '0;
            hi_reg <= '0;
            lv_reg <= '0;
            li_reg <= '0;
            pos_reg <= '0;
            sup_reg <= 1'b0;
        end
        else if (step)
        begin
            acc_reg <= acc_next;
            hv_reg <= hv_next;
            hi_reg <= hi_next;
            lv_reg <= lv_next;
            li_reg <= li_next;
            pos_reg <= pos_next;
            sup_reg <= sup_next;
        end
    end

    assign running_sum = acc_next;
    assign sample_index = idx;
    assign peak_high_value = hv_next;
    assign peak_high_index = hi_next;
    assign peak_low_value = lv_next;
    assign peak_low_index = li_next;
    assign emit = !sup_next;

endmodule

[src/thresholded_running_integral.sv]
// thresholded running integral of baseline-subtracted waveform samples
// input stream: one sample word per beat, tdata holds the sample in its low
// SAMPLE_BITS bits, tuser marks first sample and baseline found, tlast marks
// the final sample of a waveform
// output stream: one word per sample of a waveform whose baseline was found,
// carrying the running integral, its index and the peak values and indexes;
// tlast is set on the word of the last sample, where the peaks are final
// a sample is registered at the input, then integrated and compared
// combinationally and written to the output register, which drives tvalid;
// throughput one sample per cycle while the receiver does not stall, set by
// the single accumulate and compare stage
// when the receiver stalls the output register holds its word and tready
// drops once the input register is also full; no word is lost
// the apb port holds the noise threshold at address 0; the user writes it only
// while idle, which the block does not enforce; reset clears the integral,
// peaks, position and threshold; the first sample after it starts a new waveform
module thresholded_running_integral
#(
    parameter int MAX_SAMPLES = 65536,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,

    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [trint_pkg::ADDR_W-1:0]              paddr,
    input  logic [trint_pkg::DATA_W-1:0]              pwdata,
    output logic [trint_pkg::DATA_W-1:0]              prdata,
    output logic                                      pready,

    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // sample_value
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]          s_axis_tdata,
    // first_sample, baseline_found
    input  logic [1:0]                                s_axis_tuser,
    input  logic                                      s_axis_tlast,

    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // running_sum, sample_index, peak_high_value, peak_high_index,
    // peak_low_value, peak_low_index
    output logic [((3*trint_pkg::ACC_W+3*$clog2(MAX_SAMPLES)+7)/8)*8-1:0] m_axis_tdata,
    output logic                                      m_axis_tlast
);

    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int AW = trint_pkg::ACC_W;
    localparam int OUT_RAW = 3*AW + 3*IDX_W;
    localparam int OUT_W = ((OUT_RAW+7)/8)*8;

    logic [trint_pkg::THR_W-1:0]    threshold;

    logic                           in_valid_reg;
    logic                           in_valid_next;
    logic signed [SAMPLE_BITS-1:0]  sample_reg;
    trint_pkg::trint_flags_t        flags_reg;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [OUT_RAW-1:0]             out_data_reg;
    logic                           out_last_reg;

    logic                           out_free;
    logic                           step;
    logic                           take;

    logic signed [AW-1:0]           running_sum;
    logic [IDX_W-1:0]               sample_index;
    logic signed [AW-1:0]           peak_high_value;
    logic [IDX_W-1:0]               peak_high_index;
    logic signed [AW-1:0]           peak_low_value;
    logic [IDX_W-1:0]               peak_low_index;
    logic                           emit;

    trint_apb u_apb
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .noise_threshold (threshold)
    );

    assign out_free = !out_valid_reg || m_axis_tready;
    assign step = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign take = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
            flags_reg.first <= s_axis_tuser[0];
            flags_reg.found <= s_axis_tuser[1];
            flags_reg.last <= s_axis_tlast;
        end
        if (step && emit)
        begin
            out_data_reg <= {peak_low_index, peak_low_value, peak_high_index,
                             peak_high_value, sample_index, running_sum};
            out_last_reg <= flags_reg.last;
        end
    end

    trint_integ
    #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_W       (IDX_W),
        .MAX_SAMPLES (MAX_SAMPLES)
    )
    u_integ
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .sample          (sample_reg),
        .flags           (flags_reg),
        .threshold       (threshold),
        .running_sum     (running_sum),
        .sample_index    (sample_index),
        .peak_high_value (peak_high_value),
        .peak_high_index (peak_high_index),
        .peak_low_value  (peak_low_value),
        .peak_low_index  (peak_low_index),
        .emit            (emit)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = OUT_W'(out_data_reg);
    assign m_axis_tlast = out_last_reg;

endmodule
